// ===== src/cfd_pkg.sv =====
// Shared types and constants for the chunked frame deframer.
package cfd_pkg;

	// Width of the chunk size counter
	localparam int SIZE_BITS = 32;
	localparam int ACC_BITS  = SIZE_BITS + 4;

	// Token queue between front and back
	localparam int TOK_DEPTH = 4;
	localparam int TOK_AW    = $clog2(TOK_DEPTH);

	// Result queue at the output
	localparam int RES_DEPTH = 2;
	localparam int RES_AW    = $clog2(RES_DEPTH);

	// Framing characters
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LF   = 8'h0A;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HDR,
		PH_DATA,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_EOM  = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	// Classified input byte
	typedef struct packed {
		logic       is_digit;
		logic       is_hash;
		logic       is_lf;
		logic [3:0] digit;
		logic [7:0] data;
	} tok_t;

	// One result item
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} res_t;

endpackage

// ===== src/cfd_front.sv =====
// Front end: accepts stream bytes, classifies them and queues tokens.
module cfd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    in_byte,
	output logic          full,
	output cfd_pkg::tok_t tok,
	output logic          tok_valid,
	input  logic          tok_take
);

	cfd_pkg::tok_t                 mem_q [cfd_pkg::TOK_DEPTH];
	logic [cfd_pkg::TOK_AW-1:0]    wr_ptr_q;
	logic [cfd_pkg::TOK_AW-1:0]    rd_ptr_q;
	logic [cfd_pkg::TOK_AW:0]      count_q;
	logic                          wr_en;
	logic                          rd_en;
	logic [7:0]                    digit_diff;
	cfd_pkg::tok_t                 tok_new;

	// Classify the incoming byte
	always_comb begin
		digit_diff       = in_byte - cfd_pkg::CH_ZERO;
		tok_new.is_digit = (in_byte >= cfd_pkg::CH_ZERO) && (in_byte <= cfd_pkg::CH_NINE);
		tok_new.is_hash  = (in_byte == cfd_pkg::CH_HASH);
		tok_new.is_lf    = (in_byte == cfd_pkg::CH_LF);
		tok_new.digit    = digit_diff[3:0];
		tok_new.data     = in_byte;
	end

	assign full      = (count_q == (cfd_pkg::TOK_AW+1)'(cfd_pkg::TOK_DEPTH));
	assign tok_valid = (count_q != '0);
	assign wr_en     = push && !full;
	assign rd_en     = tok_take && tok_valid;
	assign tok       = mem_q[rd_ptr_q];

	// Store tokens
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= tok_new;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue never overfills and never underflows
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (cfd_pkg::TOK_AW+1)'(cfd_pkg::TOK_DEPTH))
		else $error("token queue count out of range");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !rd_en) |=> full)
		else $error("token queue left full without a read");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
		else $error("token queue count missed a write");

endmodule

// ===== src/cfd_engine.sv =====
// Back end: runs the framing state machine and queues result items.
module cfd_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  cfd_pkg::tok_t tok,
	input  logic          tok_valid,
	output logic          tok_take,
	input  logic          pop,
	output logic          empty,
	output logic [1:0]    kind,
	output logic [7:0]    data_byte
);

	cfd_pkg::phase_t                 phase_q;
	cfd_pkg::phase_t                 phase_d;
	logic [cfd_pkg::SIZE_BITS-1:0]   accum_q;
	logic [cfd_pkg::SIZE_BITS-1:0]   accum_d;
	logic [cfd_pkg::SIZE_BITS-1:0]   left_q;
	logic [cfd_pkg::SIZE_BITS-1:0]   left_d;
	logic                            seen_q;
	logic                            seen_d;
	logic [cfd_pkg::ACC_BITS-1:0]    acc_ext;
	logic [cfd_pkg::ACC_BITS-1:0]    acc_next;
	logic                            ovf;
	logic                            lf_ok;
	logic                            emit;
	cfd_pkg::res_t                   res_new;

	cfd_pkg::res_t                   rmem_q [cfd_pkg::RES_DEPTH];
	logic [cfd_pkg::RES_AW-1:0]      rwr_ptr_q;
	logic [cfd_pkg::RES_AW-1:0]      rrd_ptr_q;
	logic [cfd_pkg::RES_AW:0]        rcount_q;
	logic                            res_full;
	logic                            res_push;
	logic                            res_pop;

	// Take a token whenever the result queue has room
	assign res_full = (rcount_q == (cfd_pkg::RES_AW+1)'(cfd_pkg::RES_DEPTH));
	assign tok_take = tok_valid && !res_full;

	// Size times ten plus the new digit, with headroom to spot overflow
	always_comb begin
		acc_ext  = {4'b0000, accum_q};
		acc_next = (acc_ext << 3) + (acc_ext << 1)
			+ {{cfd_pkg::SIZE_BITS{1'b0}}, tok.digit};
		ovf      = (acc_next[cfd_pkg::ACC_BITS-1:cfd_pkg::SIZE_BITS] != 4'b0000);
		lf_ok    = tok.is_lf && seen_q && (accum_q != '0);
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (tok_take) begin
			unique case (phase_q)
				cfd_pkg::PH_HUNT: begin
					if (tok.is_hash) phase_d = cfd_pkg::PH_HDR;
				end
				cfd_pkg::PH_HDR: begin
					priority if (tok.is_digit) begin
						phase_d = ovf ? cfd_pkg::PH_HUNT : cfd_pkg::PH_HDR;
					end else if (tok.is_hash && !seen_q) begin
						phase_d = cfd_pkg::PH_SKIP;
					end else if (lf_ok) begin
						phase_d = cfd_pkg::PH_DATA;
					end else begin
						phase_d = cfd_pkg::PH_HUNT;
					end
				end
				cfd_pkg::PH_DATA: begin
					if (left_q <= cfd_pkg::SIZE_BITS'(1)) phase_d = cfd_pkg::PH_HUNT;
				end
				cfd_pkg::PH_SKIP: phase_d = cfd_pkg::PH_HUNT;
				default: phase_d = cfd_pkg::PH_HUNT;
			endcase
		end
	end

	// Size accumulator, payload counter and digit flag
	always_comb begin
		accum_d = accum_q;
		left_d  = left_q;
		seen_d  = seen_q;
		if (tok_take) begin
			unique case (phase_q)
				cfd_pkg::PH_HUNT: begin
					if (tok.is_hash) begin
						accum_d = '0;
						seen_d  = 1'b0;
					end
				end
				cfd_pkg::PH_HDR: begin
					priority if (tok.is_digit && !ovf) begin
						accum_d = acc_next[cfd_pkg::SIZE_BITS-1:0];
						seen_d  = 1'b1;
					end else if (tok.is_digit) begin
						accum_d = '0;
						seen_d  = 1'b0;
					end else if (tok.is_hash && !seen_q) begin
						accum_d = '0;
					end else if (lf_ok) begin
						left_d  = accum_q;
						accum_d = '0;
						seen_d  = 1'b0;
					end else begin
						accum_d = '0;
						seen_d  = 1'b0;
					end
				end
				cfd_pkg::PH_DATA: begin
					if (left_q != '0) left_d = left_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Result for the token taken this cycle
	always_comb begin
		emit         = 1'b0;
		res_new.kind = cfd_pkg::KIND_DATA;
		res_new.data = 8'h00;
		unique case (phase_q)
			cfd_pkg::PH_HDR: begin
				priority if (tok.is_digit) begin
					emit         = ovf;
					res_new.kind = cfd_pkg::KIND_BAD;
				end else if (tok.is_hash && !seen_q) begin
					emit         = 1'b1;
					res_new.kind = cfd_pkg::KIND_EOM;
				end else if (lf_ok) begin
					emit         = 1'b0;
				end else begin
					emit         = 1'b1;
					res_new.kind = cfd_pkg::KIND_BAD;
				end
			end
			cfd_pkg::PH_DATA: begin
				emit         = 1'b1;
				res_new.data = tok.data;
			end
			default: emit = 1'b0;
		endcase
	end

	// Hold framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfd_pkg::PH_HUNT;
			accum_q <= '0;
			left_q  <= '0;
			seen_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			left_q  <= left_d;
			seen_q  <= seen_d;
		end
	end

	// Result queue
	assign res_push  = tok_take && emit;
	assign empty     = (rcount_q == '0);
	assign res_pop   = pop && !empty;
	assign kind      = rmem_q[rrd_ptr_q].kind;
	assign data_byte = rmem_q[rrd_ptr_q].data;

	always_ff @(posedge clk) begin
		if (res_push) begin
			rmem_q[rwr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwr_ptr_q <= '0;
			rrd_ptr_q <= '0;
			rcount_q  <= '0;
		end else begin
			if (res_push) begin
				rwr_ptr_q <= rwr_ptr_q + 1'b1;
			end
			if (res_pop) begin
				rrd_ptr_q <= rrd_ptr_q + 1'b1;
			end
			if (res_push && !res_pop) begin
				rcount_q <= rcount_q + 1'b1;
			end else if (res_pop && !res_push) begin
				rcount_q <= rcount_q - 1'b1;
			end
		end
	end

	// Payload counter is never zero inside a data phase
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == cfd_pkg::PH_DATA) |-> (left_q != '0))
		else $error("data phase with no bytes left");

	// The byte after an end marker always returns to hunting
	a_skip_once: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_take && phase_q == cfd_pkg::PH_SKIP) |=> (phase_q == cfd_pkg::PH_HUNT))
		else $error("skip phase did not return to hunt");

	// A data phase is only entered with a nonzero size
	a_enter_data: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != cfd_pkg::PH_DATA) ##1 (phase_q == cfd_pkg::PH_DATA)
		|-> ($past(phase_q) == cfd_pkg::PH_HDR && left_q != '0))
		else $error("data phase entered from the wrong phase");

	// Result queue count stays in range
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcount_q <= (cfd_pkg::RES_AW+1)'(cfd_pkg::RES_DEPTH))
		else $error("result queue count out of range");

endmodule

// ===== src/chunked_frame_deframer.sv =====
// Top level of the chunked frame deframer: front classifier and back state machine.
//
// Usage: received stream bytes go in one per item on in_byte, written with
// push while full is low. Bytes outside chunks are dropped until a '#';
// then decimal digits give the chunk size and a LF opens a data phase of
// that many bytes, each passed out as a payload item (kind 0). A second
// '#' gives an end of message item (kind 1) and skips the next byte. A bad
// header byte, an empty or zero size, or a size that overflows 32 bits
// gives a malformed item (kind 2) and hunting resumes.
// Results are read like a queue: while empty is low, kind and data_byte
// show the oldest item, and pop takes it.
// Throughput is one byte per cycle while the result queue has room; the
// size update (times ten plus a digit with an overflow check) is the
// widest add per token. An accepted byte is first written to the token
// queue; the back end then takes it and writes its result to the result queue.
// Reset clears both queues and returns the framer to hunting.
// When the receiver stops popping, the two-entry result queue fills, the
// back end stops taking tokens, the four-entry token queue fills and full
// rises; no item is lost.
module chunked_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] in_byte,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output logic [1:0] kind,
	output logic [7:0] data_byte
);

	cfd_pkg::tok_t tok;
	logic          tok_valid;
	logic          tok_take;

	cfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_byte   (in_byte),
		.full      (full),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_take  (tok_take)
	);

	cfd_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_take  (tok_take),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.data_byte (data_byte)
	);

endmodule

// ===== verif/cfd_checker.sv =====
// Scoreboard for the chunked frame deframer: predicts each result item and checks it.
module cfd_checker
	import cfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] in_byte,
	input  logic       pop,
	input  logic       empty,
	input  logic [1:0] kind,
	input  logic [7:0] data_byte,
	output int         fail_count,
	output int         outstanding
);

	localparam logic [63:0] SIZE_MAX = (64'd1 << SIZE_BITS) - 64'd1;

	// Deframer state as predicted
	phase_t      frame_phase;
	logic [63:0] size_acc;
	logic [63:0] left;
	logic        seen_digit;

	// Results predicted but not yet popped, oldest first
	res_t        due_q[$];
	res_t        want;
	res_t        fresh;

	// Advance the predicted deframer by one byte; return 1 when it yields an item
	function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
		logic [63:0] size_next;
		bit          bad;
		bit          hit;
		r.kind = KIND_DATA;
		r.data = 8'h00;
		bad = 1'b0;
		hit = 1'b0;
		case (frame_phase)
			PH_HDR: begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					size_next = size_acc * 64'd10 + 64'(b - CH_ZERO);
					if (size_next > SIZE_MAX) begin
						bad = 1'b1;
					end else begin
						size_acc = size_next;
						seen_digit = 1'b1;
					end
				end else if (b == CH_HASH && !seen_digit) begin
					frame_phase = PH_SKIP;
					size_acc = '0;
					r.kind = KIND_EOM;
					hit = 1'b1;
				end else if (b == CH_LF && seen_digit && size_acc != 0) begin
					left = size_acc;
					size_acc = '0;
					seen_digit = 1'b0;
					frame_phase = PH_DATA;
				end else begin
					bad = 1'b1;
				end
			end
			PH_DATA: begin
				if (left > 0)
					left = left - 1;
				if (left == 0)
					frame_phase = PH_HUNT;
				r.data = b;
				hit = 1'b1;
			end
			PH_SKIP: begin
				frame_phase = PH_HUNT;
			end
			default: begin
				frame_phase = PH_HUNT;
				if (b == CH_HASH) begin
					frame_phase = PH_HDR;
					size_acc = '0;
					seen_digit = 1'b0;
				end
			end
		endcase
		// Malformed header: drop back to hunting
		if (bad) begin
			frame_phase = PH_HUNT;
			size_acc = '0;
			seen_digit = 1'b0;
			r.kind = KIND_BAD;
			hit = 1'b1;
		end
		return hit;
	endfunction

	// Predict on each accepted byte, compare on each popped item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_phase = PH_HUNT;
			size_acc = '0;
			left = '0;
			seen_digit = 1'b0;
			due_q.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (push && !full) begin
				if (deframe_byte(in_byte, fresh))
					due_q.push_back(fresh);
			end
			if (pop && !empty) begin
				if (due_q.size() == 0) begin
					$error("unexpected item: kind %0d data_byte 0x%02h", kind, data_byte);
					fail_count++;
				end else begin
					want = due_q.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						fail_count++;
					end
					if (data_byte !== want.data) begin
						$error("data_byte: expected 0x%02h, got 0x%02h", want.data, data_byte);
						fail_count++;
					end
				end
			end
			outstanding <= due_q.size();
		end
	end

endmodule

// ===== verif/chunked_frame_deframer_test.sv =====
// Stimulus and verdict for the chunked frame deframer, checked by cfd_checker.
module chunked_frame_deframer_test;
	import cfd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 400;

	logic       clk;
	logic       arst_n  = 1'b0;
	logic       push    = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       pop     = 1'b0;
	logic       full;
	logic       empty;
	logic [1:0] kind;
	logic [7:0] data_byte;

	int         fail_count;
	int         outstanding;
	int         taken  = 0;
	int         cycles = 0;
	int         fed;
	logic       steady;
	logic [7:0] byte_q[$];

	chunked_frame_deframer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_byte   (in_byte),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.data_byte (data_byte)
	);

	cfd_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_byte     (in_byte),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.data_byte   (data_byte),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run both sides without gaps for a stretch of the traffic
	assign steady = (taken >= 40) && (taken < 110);

	// Append a decimal number as ASCII digits
	task automatic put_num(input longint unsigned v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			byte_q.push_back(s[i]);
	endtask

	// Offer one byte, idling at random, and hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(99) < 19) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	task automatic send_all;
		while (byte_q.size() != 0)
			send_byte(byte_q.pop_front());
	endtask

	// Stop offering until every predicted item has been popped
	task automatic drain;
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Build one random frame: mostly good chunks, some end markers, noise and bad headers
	task automatic build_frame;
		int         pick;
		int         n;
		logic [7:0] b;
		bit         counted;
		counted = 1'b1;
		pick = $urandom_range(99);
		if (pick < 58) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			byte_q.push_back(CH_HASH);
			if ($urandom_range(5) == 0)
				byte_q.push_back(CH_ZERO);
			put_num(n);
			byte_q.push_back(CH_LF);
			repeat (n)
				byte_q.push_back(8'($urandom_range(255)));
		end else if (pick < 70) begin
			byte_q.push_back(CH_HASH);
			byte_q.push_back(CH_HASH);
			byte_q.push_back(8'($urandom_range(255)));
		end else if (pick < 80) begin
			counted = 1'b0;
			repeat ($urandom_range(1, 4))
				byte_q.push_back(8'($urandom_range(255)));
		end else begin
			byte_q.push_back(CH_HASH);
			case ($urandom_range(6))
				0: byte_q.push_back(CH_LF);
				1: begin
					repeat ($urandom_range(1, 3))
						byte_q.push_back(CH_ZERO);
					byte_q.push_back(CH_LF);
				end
				2: begin
					put_num($urandom_range(1, 99));
					byte_q.push_back(CH_HASH);
				end
				3: begin
					put_num($urandom_range(1, 99));
					b = 8'($urandom_range(255));
					if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_LF)
						b = 8'h78;
					byte_q.push_back(b);
				end
				4: begin
					put_num(64'd4294967295);
					byte_q.push_back(8'h78);
				end
				5: put_num(64'd4294967296);
				default: begin
					// Sizes near the limit; close with a bad byte so no huge chunk opens
					put_num(longint'({$urandom}) << $urandom_range(0, 3));
					byte_q.push_back(8'h78);
				end
			endcase
		end
		if (counted)
			fed += byte_q.size();
	endtask

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Pop at random, with one long hold-off so the block fills and stalls
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			if (!held && taken >= 150) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (60)
					@(posedge clk);
			end else begin
				pop <= steady || ($urandom_range(99) >= 19);
				@(posedge clk);
				if (pop && !empty)
					taken <= taken + 1;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		bit paused;
		paused = 1'b0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// End marker at the very first byte, then the skipped byte after it
		byte_q.push_back(CH_HASH);
		byte_q.push_back(CH_HASH);
		byte_q.push_back(8'hFF);
		// Two-byte chunk carrying both byte extremes
		byte_q.push_back(CH_HASH);
		put_num(2);
		byte_q.push_back(CH_LF);
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		// Empty size
		byte_q.push_back(CH_HASH);
		byte_q.push_back(CH_LF);
		// Zero size with a leading zero
		byte_q.push_back(CH_HASH);
		byte_q.push_back(CH_ZERO);
		byte_q.push_back(CH_ZERO);
		byte_q.push_back(CH_LF);
		// Hash after digits
		byte_q.push_back(CH_HASH);
		put_num(5);
		byte_q.push_back(CH_HASH);
		// Size one past the 32-bit limit
		byte_q.push_back(CH_HASH);
		put_num(64'd4294967296);
		send_all();
		drain();

		fed = 0;
		while (fed < ITEM_TARGET) begin
			build_frame();
			send_all();
			if (!paused && fed >= 300) begin
				paused = 1'b1;
				drain();
			end
		end
		drain();
		repeat (8)
			@(posedge clk);

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
